// File: hw/rtl/fplq_pkg.sv
// Shared types, constants and operand unpack functions for the FP32 linear quantizer.
package fplq_pkg;

   // action codes carried in the request user field
   localparam logic ACT_QUANT   = 1'b0;
   localparam logic ACT_DEQUANT = 1'b1;

   // code width modes
   localparam logic MODE_INT8  = 1'b0;
   localparam logic MODE_INT16 = 1'b1;

   // register indexes
   localparam logic [1:0] REG_SCALE = 2'd0;
   localparam logic [1:0] REG_RECIP = 2'd1;
   localparam logic [1:0] REG_MODE  = 2'd2;

   localparam logic [31:0] SCALE_RESET = 32'h3A83_126F;
   localparam logic [31:0] RECIP_RESET = 32'h447A_0000;
   localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;

   // value = man * 2^(exp-23); man not yet normalized
   typedef struct packed {
      logic              nan;
      logic              inf;
      logic              zero;
      logic              sign;
      logic signed [9:0] exp;
      logic [23:0]       man;
   } operand_type;

   function automatic operand_type unpack_float(input logic [31:0] b);
      operand_type o;
      logic [7:0]  ef;
      logic [22:0] fr;
      ef     = b[30:23];
      fr     = b[22:0];
      o.sign = b[31];
      o.nan  = (ef == 8'hFF) && (fr != 23'd0);
      o.inf  = (ef == 8'hFF) && (fr == 23'd0);
      o.zero = (ef == 8'd0) && (fr == 23'd0);
      o.man  = {(ef != 8'd0), fr};
      o.exp  = (ef == 8'd0) ? -10'sd126 : (signed'({2'b00, ef}) - 10'sd127);
      return o;
   endfunction

   function automatic operand_type unpack_int(input logic [15:0] c, input logic mode);
      operand_type o;
      logic [15:0] v;
      logic [15:0] mag;
      v      = (mode == MODE_INT16) ? c : {{8{c[7]}}, c[7:0]};
      mag    = v[15] ? (16'd0 - v) : v;
      o.sign = v[15];
      o.nan  = 1'b0;
      o.inf  = 1'b0;
      o.zero = (mag == 16'd0);
      o.man  = {8'd0, mag};
      o.exp  = 10'sd23;
      return o;
   endfunction

endpackage

// File: hw/rtl/fplq_fmul.sv
// Four-stage IEEE single-precision multiplier with round to nearest even.
module fplq_fmul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic                  in_tag,
   input  fplq_pkg::operand_type op_a,
   input  fplq_pkg::operand_type op_b,
   output logic                  out_valid,
   output logic                  out_tag,
   output logic [31:0]           out_bits
);
   import fplq_pkg::*;

   function automatic logic [4:0] lzc24(input logic [23:0] m);
      logic [4:0] n;
      logic       found;
      n     = 5'd0;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found) begin
            if (m[i]) found = 1'b1;
            else n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // flags: nan, inf, zero, sign
   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sign;
   } flags_type;

   // stage 1: normalize operands, add exponents
   logic [3:0]        v_ff, v_in;
   logic [3:0]        tag_ff;
   flags_type         f1_ff, f1_in, f2_ff, f3_ff;
   logic [23:0]       ma1_ff, ma1_in, mb1_ff, mb1_in;
   logic signed [9:0] e1_ff, e1_in;
   logic [4:0]        lza, lzb;

   always_comb begin
      lza       = lzc24(op_a.man);
      lzb       = lzc24(op_b.man);
      ma1_in    = op_a.man << lza;
      mb1_in    = op_b.man << lzb;
      e1_in     = (op_a.exp - signed'({5'd0, lza})) + (op_b.exp - signed'({5'd0, lzb}));
      f1_in.sign = op_a.sign ^ op_b.sign;
      f1_in.nan  = op_a.nan || op_b.nan || (op_a.inf && op_b.zero) || (op_a.zero && op_b.inf);
      f1_in.inf  = op_a.inf || op_b.inf;
      f1_in.zero = op_a.zero || op_b.zero;
   end

   // stage 2: significand product
   logic [47:0]       p2_ff;
   logic signed [9:0] e2_ff;

   // stage 3: normalize, denormal shift
   logic [47:0]        n3;
   logic signed [10:0] biased;
   logic [5:0]         sh;
   logic [47:0]        shifted;
   logic               lost;
   logic [23:0]        k3_ff;
   logic               g3_ff, s3_ff, big3_ff;
   logic [7:0]         eb3_ff;

   always_comb begin
      n3     = p2_ff[47] ? p2_ff : {p2_ff[46:0], 1'b0};
      biased = {e2_ff[9], e2_ff} + signed'({10'd0, p2_ff[47]}) + 11'sd127;
      if (biased > 11'sd0) sh = 6'd0;
      else if (biased < -11'sd46) sh = 6'd48;
      else sh = 6'(11'sd1 - biased);
      shifted = n3 >> sh;
      lost    = (sh == 6'd0) ? 1'b0 : |(n3 << (6'd48 - sh));
   end

   // stage 4: round and pack
   logic        up;
   logic [24:0] sum;
   logic [30:0] mag;
   logic [31:0] bits_in, bits_ff;

   always_comb begin
      up  = g3_ff && (s3_ff || k3_ff[0]);
      sum = {1'b0, k3_ff} + {24'd0, up};
      mag = {eb3_ff, 23'd0} + {6'd0, sum};
      if (f3_ff.nan) bits_in = CANON_NAN;
      else if (f3_ff.inf || (big3_ff && !f3_ff.zero)) bits_in = {f3_ff.sign, 8'hFF, 23'd0};
      else if (f3_ff.zero) bits_in = {f3_ff.sign, 31'd0};
      else bits_in = {f3_ff.sign, mag};
   end

   assign v_in = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 4'd0;
      end else if (enable) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tag_ff  <= {tag_ff[2:0], in_tag};
         f1_ff   <= f1_in;
         ma1_ff  <= ma1_in;
         mb1_ff  <= mb1_in;
         e1_ff   <= e1_in;
         f2_ff   <= f1_ff;
         p2_ff   <= ma1_ff * mb1_ff;
         e2_ff   <= e1_ff;
         f3_ff   <= f2_ff;
         k3_ff   <= shifted[47:24];
         g3_ff   <= shifted[23];
         s3_ff   <= (|shifted[22:0]) || lost;
         big3_ff <= biased > 11'sd254;
         eb3_ff  <= (biased > 11'sd0) ? 8'(biased - 11'sd1) : 8'd0;
         bits_ff <= bits_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_tag   = tag_ff[3];
   assign out_bits  = bits_ff;

endmodule

// File: hw/rtl/fp32_linear_quantizer.sv
// Top level of the FP32 linear quantizer / dequantizer stream block.
//
// Usage:
//  - req channel: one request per accepted beat. req_tuser is the action
//    (quantize float_in, or dequantize code_in). Every request gives one
//    response on the rsp channel, in order.
//  - Quantize: float_in * inverse_scale (FP32, nearest even), clamped to
//    the 8- or 16-bit signed range, rounded to integer, ties to even.
//    NaN goes to the positive limit; clamping sets saturated.
//  - Dequantize: code_in (low byte only in 8-bit mode) * scale, FP32.
//  - csr port: write-only, one register per cycle; write only while idle.
//  - Path: after the accepting edge, rsp_tvalid rises once the request has
//    passed three more multiplier stages plus the output register.
//  - Throughput: one request per cycle unless a response stalls; the shared
//    FP32 multiplier is a 4-stage pipe before the quantize/output register.
//  - Stall: when rsp_tready is low with a response held, the whole pipe
//    freezes and req_tready drops; nothing is lost or repeated.
//  - Reset: pipe valids clear, registers go to scale 0.001,
//    inverse scale 1000.0, 16-bit codes.
module fp32_linear_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] float_in, [47:32] code_in
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] code_out, [47:16] float_out,
                                    // [48] saturated, [55:49] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fplq_pkg::*;

   logic [31:0] scale_ff, recip_ff;
   logic        mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         recip_ff <= RECIP_RESET;
         mode_ff  <= MODE_INT16;
      end else if (csr_we) begin
         case (csr_index)
            REG_SCALE: scale_ff <= csr_wdata;
            REG_RECIP: recip_ff <= csr_wdata;
            REG_MODE:  mode_ff  <= csr_wdata[0];
            default:   ;
         endcase
      end
   end

   // whole pipe advances unless the output register holds a stalled response
   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   operand_type op_a, op_b;
   always_comb begin
      if (req_tuser == ACT_DEQUANT) begin
         op_a = unpack_int(req_tdata[47:32], mode_ff);
         op_b = unpack_float(scale_ff);
      end else begin
         op_a = unpack_float(req_tdata[31:0]);
         op_b = unpack_float(recip_ff);
      end
   end

   logic        m_valid, m_tag;
   logic [31:0] m_bits;

   fplq_fmul u_fmul (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_tag    (req_tuser),
      .op_a      (op_a),
      .op_b      (op_b),
      .out_valid (m_valid),
      .out_tag   (m_tag),
      .out_bits  (m_bits)
   );

   // float to saturated integer, nearest even
   logic [7:0]  ef;
   logic [23:0] mq;
   logic [5:0]  qsh;
   logic [47:0] qx;
   logic [16:0] ip, rnd, hi, lo_mag, lim;
   logic        g, s, over, is_nan, neg, sat;
   logic [15:0] code;

   always_comb begin
      ef     = m_bits[30:23];
      mq     = {(ef != 8'd0), m_bits[22:0]};
      is_nan = (ef == 8'hFF) && (m_bits[22:0] != 23'd0);
      neg    = m_bits[31] && !is_nan;
      over   = ef >= 8'd143;
      qsh    = (ef < 8'd126) ? 6'd25 : 6'(8'd150 - ef);
      qx     = {mq, 24'd0} >> qsh;
      ip     = qx[40:24];
      g      = qx[23];
      s      = |qx[22:0];
      hi     = (mode_ff == MODE_INT16) ? 17'd32767 : 17'd127;
      lo_mag = (mode_ff == MODE_INT16) ? 17'd32768 : 17'd128;
      lim    = neg ? lo_mag : hi;
      sat    = is_nan || over || (ip > lim) || ((ip == lim) && (g || s));
      rnd    = ip + {16'd0, g && (s || ip[0])};
      if (sat) code = neg ? 16'(17'd0 - lo_mag) : hi[15:0];
      else code = neg ? 16'(17'd0 - rnd) : rnd[15:0];
   end

   logic        out_valid_ff;
   logic [15:0] code_ff;
   logic [31:0] float_ff;
   logic        sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (m_tag == ACT_DEQUANT) begin
            code_ff  <= 16'd0;
            float_ff <= m_bits;
            sat_ff   <= 1'b0;
         end else begin
            code_ff  <= code;
            float_ff <= 32'd0;
            sat_ff   <= sat;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, sat_ff, float_ff, code_ff};

endmodule

// File: hw/rtl/fplq_checker.sv
// Port-level checks for the FP32 linear quantizer, bound to the top level.
module fplq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // an empty output stage never blocks requests
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // a response carries either a code or a float, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] == 16'd0 && !rsp_tdata[48])
                     || rsp_tdata[47:16] == 32'd0)
      else $error("response mixes code and float");

   // saturation only at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |->
         rsp_tdata[15:0] == 16'h7FFF || rsp_tdata[15:0] == 16'h8000 ||
         rsp_tdata[15:0] == 16'h007F || rsp_tdata[15:0] == 16'hFF80)
      else $error("saturated code off limit");

   // reset empties the pipe
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind fp32_linear_quantizer fplq_checker u_fplq_checker (.*);
